// ===== hw/rtl/wmqs_pkg.sv =====
`timescale 1ns / 1ps
package wmqs_pkg;

	localparam int WINDOW_MAX_DEF = 64;
	localparam int EXP_ENTRIES_DEF = 64;
	localparam int QUEUE_DEPTH = 2;

	localparam int MOT_W = 16;
	localparam int STAB_W = 17;
	localparam int SCORE_W = 16;
	localparam int GAIN_W = 8;
	localparam int WLEN_IN_W = 7;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int Q30_W = 31;

	localparam int WINDOW_RESET = 64;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd50;
	localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd22938;

	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [14:0] STAB_WEIGHT = 15'd19661;
	localparam logic [13:0] COH_WEIGHT = 14'd13107;
	localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [Q30_W-1:0] HALF_Q30 = 31'h2000_0000;
	localparam logic [SCORE_W-1:0] SCORE_ONE = 16'd32768;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_GAIN = 2'd1;
	localparam logic [1:0] REG_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [SCORE_W-1:0] threshold;
	} cfg_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SQ,
		F_UPD,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SQ,
		B_NUM,
		B_DIVV,
		B_VLOAD,
		B_DIVS,
		B_GAIN,
		B_EXPO,
		B_IDX,
		B_LOOK,
		B_COH,
		B_QUAL
	} back_state_t;

	typedef enum logic [2:0] {
		T_MID,
		T_POW,
		T_CMP,
		T_FILL,
		T_DONE
	} table_state_t;

	function automatic int cnt_w(input int wmax);
		return $clog2(wmax + 1);
	endfunction

	function automatic int sumd_w(input int wmax);
		return MOT_W + $clog2(wmax);
	endfunction

	function automatic int sq_w(input int wmax);
		return 2 * MOT_W + $clog2(wmax);
	endfunction

	function automatic int sst_w(input int wmax);
		return STAB_W + $clog2(wmax);
	endfunction

	function automatic int sums_w(input int wmax);
		return cnt_w(wmax) + 2 * sumd_w(wmax) + sq_w(wmax) + sst_w(wmax);
	endfunction

endpackage

// ===== hw/rtl/wmqs_ram.sv =====
`timescale 1ns / 1ps
module wmqs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/wmqs_queue.sv =====
`timescale 1ns / 1ps
module wmqs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_ok, pop_ok})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hw/rtl/wmqs_front.sv =====
`timescale 1ns / 1ps
module wmqs_front #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [wmqs_pkg::MOT_W-1:0]             motion_dx,
	input  logic signed [wmqs_pkg::MOT_W-1:0]             motion_dy,
	input  logic signed [wmqs_pkg::STAB_W-1:0]            stability_score,
	input  logic                                          clear,
	input  logic [wmqs_pkg::cnt_w(WINDOW_MAX)-1:0]        window_length,
	output logic                                          sums_valid,
	input  logic                                          sums_ready,
	output logic [wmqs_pkg::sums_w(WINDOW_MAX)-1:0]       sums_data
);

	import wmqs_pkg::*;

	localparam int CNT_W = cnt_w(WINDOW_MAX);
	localparam int SLOT_W = $clog2(WINDOW_MAX);
	localparam int SUMD_W = sumd_w(WINDOW_MAX);
	localparam int SQ_W = sq_w(WINDOW_MAX);
	localparam int SST_W = sst_w(WINDOW_MAX);
	localparam int SQ1_W = 2 * MOT_W;
	localparam int ENTRY_W = 2 * MOT_W + STAB_W;

	front_state_t state_q, state_d;

	logic signed [MOT_W-1:0]  dx_q, dy_q, odx_q, ody_q;
	logic signed [STAB_W-1:0] st_q, ost_q;
	logic [SQ1_W-1:0]         old_sq_q, new_sq_q;
	logic [CNT_W-1:0]         fill_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [SUMD_W-1:0] sum_dx_q, sum_dy_q;
	logic [SQ_W-1:0]          sum_sq_q;
	logic signed [SST_W-1:0]  sum_st_q;

	logic [SLOT_W:0]          old_raw;
	logic [SLOT_W-1:0]        old_addr;
	logic [ENTRY_W-1:0]       rd_entry;
	logic signed [MOT_W-1:0]  rd_dx, rd_dy;
	logic signed [STAB_W-1:0] rd_st;
	logic signed [SQ1_W-1:0]  ndx2, ndy2;
	logic                     evict;
	logic                     ring_wr;

	assign old_raw = {1'b0, slot_q} + (SLOT_W + 1)'(WINDOW_MAX) - (SLOT_W + 1)'(fill_q);
	assign old_addr = (old_raw >= (SLOT_W + 1)'(WINDOW_MAX)) ?
		SLOT_W'(old_raw - (SLOT_W + 1)'(WINDOW_MAX)) : SLOT_W'(old_raw);
	assign {rd_dx, rd_dy, rd_st} = rd_entry;
	assign evict = (fill_q >= window_length);

	assign ndx2 = dx_q * dx_q;
	assign ndy2 = dy_q * dy_q;

	wmqs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk(clk),
		.wr_en(ring_wr),
		.wr_addr(slot_q),
		.wr_data({dx_q, dy_q, st_q}),
		.rd_addr(old_addr),
		.rd_data(rd_entry)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					state_d = F_SQ;
				end
			end
			F_SQ: state_d = F_UPD;
			F_UPD: state_d = F_PUSH;
			F_PUSH: begin
				if (sums_ready) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		sums_valid = 1'b0;
		ring_wr = 1'b0;
		case (state_q)
			F_IDLE: in_ready = 1'b1;
			F_UPD: ring_wr = 1'b1;
			F_PUSH: sums_valid = 1'b1;
			default: ;
		endcase
	end

	assign sums_data = {fill_q, sum_dx_q, sum_dy_q, sum_sq_q, sum_st_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			fill_q <= '0;
			slot_q <= '0;
			sum_dx_q <= '0;
			sum_dy_q <= '0;
			sum_sq_q <= '0;
			sum_st_q <= '0;
		end else begin
			state_q <= state_d;
			if (clear) begin
				fill_q <= '0;
				slot_q <= '0;
				sum_dx_q <= '0;
				sum_dy_q <= '0;
				sum_sq_q <= '0;
				sum_st_q <= '0;
			end else if (state_q == F_UPD) begin
				sum_dx_q <= sum_dx_q - (evict ? SUMD_W'(odx_q) : '0) + SUMD_W'(dx_q);
				sum_dy_q <= sum_dy_q - (evict ? SUMD_W'(ody_q) : '0) + SUMD_W'(dy_q);
				sum_sq_q <= sum_sq_q - (evict ? SQ_W'(old_sq_q) : '0) + SQ_W'(new_sq_q);
				sum_st_q <= sum_st_q - (evict ? SST_W'(ost_q) : '0) + SST_W'(st_q);
				if (!evict) begin
					fill_q <= fill_q + 1'b1;
				end
				slot_q <= (slot_q == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			dx_q <= motion_dx;
			dy_q <= motion_dy;
			st_q <= stability_score;
		end
		if (state_q == F_SQ) begin
			odx_q <= rd_dx;
			ody_q <= rd_dy;
			ost_q <= rd_st;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_SQ) begin
			new_sq_q <= SQ1_W'(ndx2) + SQ1_W'(ndy2);
		end
		if (state_q == F_SQ) begin
			old_sq_q <= SQ1_W'(rd_dx * rd_dx) + SQ1_W'(rd_dy * rd_dy);
		end
	end

endmodule

// ===== hw/rtl/wmqs_exp_table.sv =====
`timescale 1ns / 1ps
module wmqs_exp_table #(
	parameter int EXP_TABLE_ENTRIES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	output logic                                 ready,
	input  logic [$clog2(EXP_TABLE_ENTRIES)-1:0] rd_addr,
	output logic [wmqs_pkg::Q30_W-1:0]           rd_data
);

	import wmqs_pkg::*;

	localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
	localparam int PCNT_W = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int PROD_W = 2 * Q30_W;

	table_state_t state_q, state_d;

	logic [Q30_W-1:0]  lo_q, hi_q, mid_q, p_q, prev_q;
	logic [PCNT_W-1:0] cnt_q;
	logic [IDX_W-1:0]  j_q;

	logic [Q30_W:0]    mid_sum;
	logic [PROD_W-1:0] pprod, fprod;
	logic [Q30_W-1:0]  wr_data;
	logic              wr_en;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (Q30_W + 1)'(1);
	assign pprod = PROD_W'(p_q) * PROD_W'(mid_q);
	assign fprod = PROD_W'(prev_q) * PROD_W'(lo_q) + PROD_W'(HALF_Q30);

	wmqs_ram #(
		.WIDTH(Q30_W),
		.DEPTH(EXP_TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(j_q),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			T_MID: state_d = (lo_q < hi_q) ? T_POW : T_FILL;
			T_POW: begin
				if (cnt_q == PCNT_W'(EXP_TABLE_ENTRIES - 1)) begin
					state_d = T_CMP;
				end
			end
			T_CMP: state_d = T_MID;
			T_FILL: begin
				if (j_q == IDX_W'(EXP_TABLE_ENTRIES - 1)) begin
					state_d = T_DONE;
				end
			end
			T_DONE: state_d = T_DONE;
			default: state_d = T_MID;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		ready = 1'b0;
		wr_data = (j_q == '0) ? ONE_Q30 : fprod[2 * 30 :30];
		case (state_q)
			T_FILL: wr_en = 1'b1;
			T_DONE: ready = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_MID;
			lo_q <= HALF_Q30;
			hi_q <= ONE_Q30;
			cnt_q <= '0;
			j_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				T_MID: cnt_q <= '0;
				T_POW: cnt_q <= cnt_q + 1'b1;
				T_CMP: begin
					if (p_q <= HALF_Q30) begin
						lo_q <= mid_q;
					end else begin
						hi_q <= mid_q - 1'b1;
					end
				end
				T_FILL: j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_MID: begin
				mid_q <= mid_sum[Q30_W:1];
				p_q <= ONE_Q30;
			end
			T_POW: p_q <= pprod[2 * 30:30];
			T_FILL: prev_q <= wr_data;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/wmqs_back.sv =====
`timescale 1ns / 1ps
module wmqs_back #(
	parameter int WINDOW_MAX = 64,
	parameter int EXP_TABLE_ENTRIES = 64
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    sums_avail,
	output logic                                    sums_pop,
	input  logic [wmqs_pkg::sums_w(WINDOW_MAX)-1:0] sums_data,
	input  wmqs_pkg::cfg_t                          cfg,
	input  logic                                    table_ready,
	output logic [$clog2(EXP_TABLE_ENTRIES)-1:0]    table_addr,
	input  logic [wmqs_pkg::Q30_W-1:0]              table_data,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [wmqs_pkg::SCORE_W-1:0]            coherence_score,
	output logic [wmqs_pkg::SCORE_W-1:0]            mean_stability,
	output logic [wmqs_pkg::SCORE_W-1:0]            quality_index,
	output logic                                    passes
);

	import wmqs_pkg::*;

	localparam int CNT_W = cnt_w(WINDOW_MAX);
	localparam int SUMD_W = sumd_w(WINDOW_MAX);
	localparam int SQ_W = sq_w(WINDOW_MAX);
	localparam int SST_W = sst_w(WINDOW_MAX);
	localparam int NS_W = SQ_W + CNT_W;
	localparam int SX2_W = 2 * SUMD_W;
	localparam int CMP_W = (NS_W > SX2_W + 1) ? NS_W : SX2_W + 1;
	localparam int DVS_W = 2 * CNT_W;
	localparam int DCNT_W = $clog2(CMP_W + 1);
	localparam int VAR_W = 32;
	localparam int P_W = GAIN_W + VAR_W;
	localparam int TP_W = 37;
	localparam int T_W = 21;
	localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
	localparam int Q_W = 31;

	back_state_t state_q, state_d;

	logic [CNT_W-1:0]         n_in, n_q;
	logic signed [SUMD_W-1:0] sdx_in, sdy_in, sdx_q, sdy_q;
	logic [SQ_W-1:0]          sq_in, sq_q;
	logic signed [SST_W-1:0]  sst_in, sst_q;

	logic [NS_W-1:0]          ns_q;
	logic [SX2_W-1:0]         sx2_q, sy2_q;
	logic [CMP_W-1:0]         quo_q;
	logic [DVS_W-1:0]         rem_q, div_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [VAR_W-1:0]         var_q;
	logic                     vsat_q, cz_q;
	logic [P_W-1:0]           p_q;
	logic [T_W-1:0]           t_q;
	logic [3:0]               k_q;
	logic [IDX_W-1:0]         idx_q;
	logic [SCORE_W-1:0]       stab_q, coh_q;

	logic                     out_valid_q, passes_q;
	logic [SCORE_W-1:0]       coh_out_q, stab_out_q, q_out_q;

	logic signed [SX2_W-1:0]  sx2_c, sy2_c;
	logic [CMP_W-1:0]         sxy, nsx, num;
	logic [DVS_W:0]           rem_sh, rem_diff;
	logic                     ge;
	logic                     last_step;
	logic [TP_W-1:0]          tprod;
	logic [31:0]              fe;
	logic [31:0]              csum, cshift;
	logic [4:0]               rnd_sh, out_sh;
	logic [Q_W-1:0]           qsum;
	logic [SCORE_W-1:0]       q_val;
	logic                     out_free;
	logic                     load_out;

	assign {n_in, sdx_in, sdy_in, sq_in, sst_in} = sums_data;

	assign sx2_c = sdx_q * sdx_q;
	assign sy2_c = sdy_q * sdy_q;
	assign sxy = CMP_W'(sx2_q) + CMP_W'(sy2_q);
	assign nsx = CMP_W'(ns_q);
	assign num = (nsx >= sxy) ? nsx - sxy : '0;

	assign rem_sh = {rem_q, quo_q[CMP_W-1]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign ge = (rem_sh >= {1'b0, div_q});
	assign last_step = (dcnt_q == DCNT_W'(CMP_W - 1));

	assign tprod = TP_W'(p_q[19:0]) * TP_W'(LOG2E_Q16);
	assign fe = 32'(t_q[15:0]) * 32'(EXP_TABLE_ENTRIES);

	assign rnd_sh = {1'b0, k_q} + 5'd14;
	assign out_sh = {1'b0, k_q} + 5'd15;
	assign csum = 32'(table_data) + (32'd1 << rnd_sh);
	assign cshift = csum >> out_sh;

	assign qsum = Q_W'(STAB_WEIGHT) * Q_W'(stab_q) + Q_W'(COH_WEIGHT) * Q_W'(coh_q)
		+ Q_W'(16384);
	assign q_val = qsum[Q_W-1:15];

	assign out_free = !out_valid_q || out_ready;
	assign table_addr = idx_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (sums_avail && table_ready) begin
					state_d = B_SQ;
				end
			end
			B_SQ: state_d = B_NUM;
			B_NUM: state_d = B_DIVV;
			B_DIVV: begin
				if (last_step) begin
					state_d = B_VLOAD;
				end
			end
			B_VLOAD: state_d = B_DIVS;
			B_DIVS: begin
				if (last_step) begin
					state_d = B_GAIN;
				end
			end
			B_GAIN: state_d = B_EXPO;
			B_EXPO: state_d = B_IDX;
			B_IDX: state_d = B_LOOK;
			B_LOOK: state_d = B_COH;
			B_COH: state_d = B_QUAL;
			B_QUAL: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		sums_pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_IDLE: sums_pop = sums_avail && table_ready;
			B_QUAL: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_NUM: dcnt_q <= '0;
				B_VLOAD: dcnt_q <= '0;
				B_DIVV: dcnt_q <= dcnt_q + 1'b1;
				B_DIVS: dcnt_q <= dcnt_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				n_q <= n_in;
				sdx_q <= sdx_in;
				sdy_q <= sdy_in;
				sq_q <= sq_in;
				sst_q <= sst_in;
			end
			B_SQ: begin
				ns_q <= NS_W'(n_q) * NS_W'(sq_q);
				sx2_q <= sx2_c;
				sy2_q <= sy2_c;
			end
			B_NUM: begin
				quo_q <= num;
				rem_q <= '0;
				div_q <= DVS_W'(n_q) * DVS_W'(n_q);
			end
			B_DIVV, B_DIVS: begin
				rem_q <= ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				quo_q <= {quo_q[CMP_W-2:0], ge};
			end
			B_VLOAD: begin
				var_q <= quo_q[VAR_W-1:0];
				vsat_q <= (quo_q[CMP_W-1:VAR_W] != '0);
				quo_q <= (sst_q > 0) ? CMP_W'($unsigned(sst_q)) : '0;
				rem_q <= '0;
				div_q <= DVS_W'(n_q);
			end
			B_GAIN: begin
				if (sst_q <= 0) begin
					stab_q <= '0;
				end else if (quo_q > CMP_W'(SCORE_ONE)) begin
					stab_q <= SCORE_ONE;
				end else begin
					stab_q <= quo_q[SCORE_W-1:0];
				end
				p_q <= P_W'(cfg.gain) * P_W'(var_q);
			end
			B_EXPO: begin
				t_q <= tprod[TP_W-1:16];
				cz_q <= vsat_q || (p_q[P_W-1:20] != '0);
			end
			B_IDX: begin
				cz_q <= cz_q || t_q[T_W-1];
				k_q <= t_q[19:16];
				idx_q <= fe[16 +: IDX_W];
			end
			B_COH: coh_q <= cz_q ? '0 : cshift[SCORE_W-1:0];
			default: ;
		endcase
		if (load_out) begin
			coh_out_q <= coh_q;
			stab_out_q <= stab_q;
			q_out_q <= q_val;
			passes_q <= (q_val >= cfg.threshold);
		end
	end

	assign out_valid = out_valid_q;
	assign coherence_score = coh_out_q;
	assign mean_stability = stab_out_q;
	assign quality_index = q_out_q;
	assign passes = passes_q;

endmodule

// ===== hw/rtl/windowed_motion_quality_score_core.sv =====
`timescale 1ns / 1ps
// Motion quality scorer. Each item is one frame's global motion (dx, dy, Q8.8)
// and stability score (signed Q2.15); each item yields one result with coherence,
// mean stability, quality and a pass flag. The front takes one item at a time
// (ring read, square, sum update, hand-off) into a two-entry queue, and waits
// in hand-off while the queue is full. The back computes variance and mean
// stability with one shared bit-serial restoring divider, whose dividend is 45 bits
// wide at WINDOW_MAX = 64, so the back sets the item rate. After reset the
// exponent table is built by a binary search for its ratio and then filled
// entry by entry; items are taken in that time until the queue fills, results
// follow once the table is ready.
// Writing window_length empties the window; write registers only while idle.
module windowed_motion_quality_score_core #(
	parameter int WINDOW_MAX = wmqs_pkg::WINDOW_MAX_DEF,
	parameter int EXP_TABLE_ENTRIES = wmqs_pkg::EXP_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [wmqs_pkg::ADDR_W-1:0]        paddr,
	input  logic [wmqs_pkg::DATA_W-1:0]        pwdata,
	output logic [wmqs_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [wmqs_pkg::MOT_W-1:0]  motion_dx,
	input  logic signed [wmqs_pkg::MOT_W-1:0]  motion_dy,
	input  logic signed [wmqs_pkg::STAB_W-1:0] stability_score,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wmqs_pkg::SCORE_W-1:0]       coherence_score,
	output logic [wmqs_pkg::SCORE_W-1:0]       mean_stability,
	output logic [wmqs_pkg::SCORE_W-1:0]       quality_index,
	output logic                               passes
);

	import wmqs_pkg::*;

	localparam int CNT_W = cnt_w(WINDOW_MAX);
	localparam int SUMS_W = sums_w(WINDOW_MAX);
	localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
	localparam int WLEN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

	logic [CNT_W-1:0]   wlen_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SCORE_W-1:0] thr_q;
	logic [1:0]         reg_idx;
	logic               reg_wr;
	logic               clear;
	logic [31:0]        wlen_raw;
	logic [31:0]        wlen_sat;
	cfg_t               cfg;

	logic               sums_valid, sums_ready, q_full, q_empty, sums_pop;
	logic [SUMS_W-1:0]  sums_in, sums_out;
	logic               table_ready;
	logic [IDX_W-1:0]   table_addr;
	logic [Q30_W-1:0]   table_data;

	assign pready = 1'b1;
	assign reg_idx = paddr[3:2];
	assign reg_wr = psel && penable && pwrite;
	assign clear = reg_wr && (reg_idx == REG_WINDOW);
	assign wlen_raw = 32'(pwdata[WLEN_IN_W-1:0]);
	assign wlen_sat = (wlen_raw == 32'd0) ? 32'd1 :
		((wlen_raw > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX) : wlen_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= CNT_W'(WLEN_RST);
			gain_q <= GAIN_RESET;
			thr_q <= THRESHOLD_RESET;
		end else if (reg_wr) begin
			case (reg_idx)
				REG_WINDOW: wlen_q <= CNT_W'(wlen_sat);
				REG_GAIN: gain_q <= pwdata[GAIN_W-1:0];
				REG_THRESHOLD: thr_q <= pwdata[SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WINDOW: prdata = DATA_W'(wlen_q);
			REG_GAIN: prdata = DATA_W'(gain_q);
			REG_THRESHOLD: prdata = DATA_W'(thr_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.gain = gain_q;
	assign cfg.threshold = thr_q;
	assign sums_ready = !q_full;

	wmqs_front #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.motion_dx(motion_dx),
		.motion_dy(motion_dy),
		.stability_score(stability_score),
		.clear(clear),
		.window_length(wlen_q),
		.sums_valid(sums_valid),
		.sums_ready(sums_ready),
		.sums_data(sums_in)
	);

	wmqs_queue #(
		.WIDTH(SUMS_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(sums_valid),
		.push_data(sums_in),
		.full(q_full),
		.pop(sums_pop),
		.pop_data(sums_out),
		.empty(q_empty)
	);

	wmqs_exp_table #(
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_table (
		.clk(clk),
		.arst_n(arst_n),
		.ready(table_ready),
		.rd_addr(table_addr),
		.rd_data(table_data)
	);

	wmqs_back #(
		.WINDOW_MAX(WINDOW_MAX),
		.EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.sums_avail(!q_empty),
		.sums_pop(sums_pop),
		.sums_data(sums_out),
		.cfg(cfg),
		.table_ready(table_ready),
		.table_addr(table_addr),
		.table_data(table_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.coherence_score(coherence_score),
		.mean_stability(mean_stability),
		.quality_index(quality_index),
		.passes(passes)
	);

`ifndef SYNTHESIS
	a_pass_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (passes == (quality_index >= thr_q)))
		else $error("pass flag disagrees with quality and threshold");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (coherence_score <= SCORE_ONE && mean_stability <= SCORE_ONE
			&& quality_index <= SCORE_ONE))
		else $error("score above one");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("front took a second item while busy");

	a_queue_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sums_valid && q_full) |=> sums_valid)
		else $error("front dropped window totals against a full queue");
`endif

endmodule

// ===== tb/windowed_motion_quality_score_core_tb.sv =====
`timescale 1ns / 1ps
module windowed_motion_quality_score_core_tb;
	import wmqs_pkg::*;

	localparam int WIN = WINDOW_MAX_DEF;
	localparam int TAB = EXP_ENTRIES_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [MOT_W-1:0] dx;
		logic signed [MOT_W-1:0] dy;
		logic signed [STAB_W-1:0] st;
	} frame_t;

	typedef struct {
		logic [SCORE_W-1:0] coh;
		logic [SCORE_W-1:0] stab;
		logic [SCORE_W-1:0] qual;
		logic pass;
	} score_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic signed [MOT_W-1:0] motion_dx = '0;
	logic signed [MOT_W-1:0] motion_dy = '0;
	logic signed [STAB_W-1:0] stability_score = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [SCORE_W-1:0] coherence_score;
	logic [SCORE_W-1:0] mean_stability;
	logic [SCORE_W-1:0] quality_index;
	logic passes;

	windowed_motion_quality_score_core i_dut (.*);

	frame_t pending_frames[$];
	score_t expected_scores[$];
	frame_t cur_frame;
	longint unsigned exp_table[TAB];
	longint dx_hist[WIN];
	longint dy_hist[WIN];
	longint st_hist[WIN];
	int fill_cnt;
	int head_slot;
	longint acc_dx, acc_dy, acc_sq, acc_st;
	int win_len;
	int gain;
	int threshold;
	int mismatches = 0;
	int frames_sent = 0;
	int scores_seen = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit calm = 0;
	bit live = 0;
	int quiet_cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned pow_q30(longint unsigned r);
		longint unsigned p;
		p = 64'd1 << 30;
		for (int i = 0; i < TAB; i++)
			p = (p * r) >> 30;
		return p;
	endfunction

	function automatic void build_exp_table();
		longint unsigned lo, hi, mid;
		lo = 64'd1 << 29;
		hi = 64'd1 << 30;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (pow_q30(mid) <= (64'd1 << 29))
				lo = mid;
			else
				hi = mid - 1;
		end
		exp_table[0] = 64'd1 << 30;
		for (int j = 1; j < TAB; j++)
			exp_table[j] = (exp_table[j-1] * lo + (64'd1 << 29)) >> 30;
	endfunction

	function automatic void clear_window();
		fill_cnt = 0;
		head_slot = 0;
		acc_dx = 0;
		acc_dy = 0;
		acc_sq = 0;
		acc_st = 0;
	endfunction

	function automatic score_t score_frame(frame_t f);
		longint n, num, spread, dx, dy, st;
		longint unsigned t, coh, stab, q;
		int k, old, idx;
		score_t r;
		dx = f.dx;
		dy = f.dy;
		st = f.st;
		if (fill_cnt >= win_len && fill_cnt > 0) begin
			old = (head_slot + WIN - fill_cnt) % WIN;
			acc_dx -= dx_hist[old];
			acc_dy -= dy_hist[old];
			acc_sq -= dx_hist[old] * dx_hist[old] + dy_hist[old] * dy_hist[old];
			acc_st -= st_hist[old];
			fill_cnt--;
		end
		dx_hist[head_slot] = dx;
		dy_hist[head_slot] = dy;
		st_hist[head_slot] = st;
		acc_dx += dx;
		acc_dy += dy;
		acc_sq += dx * dx + dy * dy;
		acc_st += st;
		head_slot = (head_slot + 1) % WIN;
		fill_cnt++;
		n = fill_cnt;
		num = n * acc_sq - acc_dx * acc_dx - acc_dy * acc_dy;
		if (num < 0)
			num = 0;
		spread = num / (n * n);
		t = (longint'(gain) * spread * longint'(LOG2E_Q16)) >> 16;
		if ((t >> 16) >= 16) begin
			coh = 0;
		end else begin
			k = int'(t >> 16);
			idx = int'(((t & 64'hFFFF) * TAB) >> 16);
			coh = (exp_table[idx] + (64'd1 << (14 + k))) >> (15 + k);
		end
		if (acc_st <= 0) begin
			stab = 0;
		end else begin
			stab = acc_st / n;
			if (stab > SCORE_ONE)
				stab = SCORE_ONE;
		end
		q = (longint'(STAB_WEIGHT) * stab + longint'(COH_WEIGHT) * coh + 16384) >> 15;
		r.coh = coh[SCORE_W-1:0];
		r.stab = stab[SCORE_W-1:0];
		r.qual = q[SCORE_W-1:0];
		r.pass = (q >= threshold);
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		mismatches++;
		$display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_scores.insert(expected_scores.size(), score_frame(cur_frame));
			frames_sent++;
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 0;
			end else if (live && pending_frames.size() > 0) begin
				cur_frame = pending_frames.pop_front();
				motion_dx <= cur_frame.dx;
				motion_dy <= cur_frame.dy;
				stability_score <= cur_frame.st;
				in_valid <= 1;
				if (!calm && $urandom_range(0, 5) == 0)
					in_gap = $urandom_range(1, 5);
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk) begin
		score_t want;
		if (out_valid && out_ready) begin
			scores_seen++;
			if (expected_scores.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_scores.pop_front();
				if (coherence_score !== want.coh)
					report_mismatch("coherence_score", coherence_score, want.coh);
				if (mean_stability !== want.stab)
					report_mismatch("mean_stability", mean_stability, want.stab);
				if (quality_index !== want.qual)
					report_mismatch("quality_index", quality_index, want.qual);
				if (passes !== want.pass)
					report_mismatch("passes", passes, want.pass);
			end
		end
		if (out_gap > 0) begin
			out_gap--;
			out_ready <= 0;
		end else begin
			out_ready <= live;
			if (!calm && $urandom_range(0, 5) == 0)
				out_gap = $urandom_range(1, 5);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] index, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (index)
			REG_WINDOW: begin
				win_len = value[6:0];
				if (win_len < 1)
					win_len = 1;
				if (win_len > WIN)
					win_len = WIN;
				clear_window();
			end
			REG_GAIN: gain = value[7:0];
			REG_THRESHOLD: threshold = value[15:0];
			default: ;
		endcase
	endtask

	task automatic push_frame(int dx, int dy, int st);
		frame_t f;
		f.dx = dx;
		f.dy = dy;
		f.st = st;
		pending_frames.insert(pending_frames.size(), f);
	endtask

	task automatic push_random(int count);
		int bx, by, sp, sb;
		bx = $urandom_range(0, 65535) - 32768;
		by = $urandom_range(0, 65535) - 32768;
		sb = $urandom_range(0, 36000);
		sp = $urandom_range(0, 3) == 0 ? 2000 : $urandom_range(0, 160);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				push_frame($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
					$urandom_range(0, 131071) - 65536);
			else
				push_frame(((bx + $urandom_range(0, 2 * sp) - sp) & 16'hFFFF),
					((by + $urandom_range(0, 2 * sp) - sp) & 16'hFFFF),
					sb + $urandom_range(0, 8000) - 4000);
		end
	endtask

	task automatic drain();
		while (pending_frames.size() > 0 || expected_scores.size() > 0 || in_valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		build_exp_table();
		win_len = WINDOW_RESET;
		gain = GAIN_RESET;
		threshold = THRESHOLD_RESET;
		clear_window();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		live <= 1;

		push_frame(0, 0, 32768);
		push_frame(0, 0, 32768);
		push_frame(-32768, 32767, 65535);
		push_frame(32767, -32768, -65536);
		push_frame(5, 5, 0);
		push_frame(6, 4, 20000);
		push_frame(4, 6, 65535);
		drain();

		reg_write(REG_WINDOW, 0);
		push_frame(100, -100, 30000);
		push_frame(-32768, -32768, -1);
		push_frame(1, 1, 1);
		drain();
		reg_write(REG_GAIN, 0);
		reg_write(REG_THRESHOLD, 32768);
		reg_write(REG_WINDOW, 3);
		push_frame(32767, 32767, 65535);
		push_frame(-32768, -32768, 65535);
		push_frame(0, 0, 65535);
		push_frame(0, 0, 40000);
		drain();
		reg_write(REG_GAIN, 255);
		reg_write(REG_THRESHOLD, 0);
		reg_write(REG_UNUSED, 32'hFFFF_FFFF);
		reg_write(REG_WINDOW, 127);
		push_frame(256, 0, 32768);
		push_frame(0, 256, 32768);
		push_frame(1, 0, 32768);
		push_frame(0, 1, 32768);
		push_frame(-32768, 0, 32767);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: reg_write(REG_WINDOW, 64);
				1: reg_write(REG_WINDOW, 1);
				2: reg_write(REG_WINDOW, 2);
				default: reg_write(REG_WINDOW, $urandom_range(0, 127));
			endcase
			reg_write(REG_GAIN, p == 3 ? 0 : (p == 4 ? 255 : $urandom_range(0, 255)));
			reg_write(REG_THRESHOLD, p == 5 ? 32768 : $urandom_range(0, 32768));
			if (p == 7)
				calm = 1;
			for (int b = 0; b < 5; b++)
				push_random(30);
			drain();
		end

		repeat (300) @(posedge clk);
		$display("%0d frames scored over 12 register settings, %0d results checked",
			frames_sent, scores_seen);
		if (mismatches == 0 && expected_scores.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, expected_scores.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
